[rtl/todt_pkg.sv]
// ----------------------------------------------------------------------------
// todt_pkg
// Shared types and codes of the timer occurrence dedup tracker.
// ----------------------------------------------------------------------------
package todt_pkg;

	localparam int DEF_SLOT_COUNT = 8;

	localparam logic [31:0] LIMIT_RESET = 32'd4;

	// stream widths
	localparam int IN_DATA_W  = 96;
	localparam int IN_USER_W  = 3;
	localparam int OUT_DATA_W = 200;

	// event codes
	localparam logic [2:0] MODE_ARM   = 3'd0;
	localparam logic [2:0] MODE_TRY   = 3'd1;
	localparam logic [2:0] MODE_DEQ   = 3'd2;
	localparam logic [2:0] MODE_BEGIN = 3'd3;
	localparam logic [2:0] MODE_END   = 3'd4;
	localparam logic [2:0] MODE_DROP  = 3'd5;

	// verdict codes
	localparam logic [1:0] VERDICT_VALID   = 2'd0;
	localparam logic [1:0] VERDICT_DUP     = 2'd1;
	localparam logic [1:0] VERDICT_BACKLOG = 2'd2;

	typedef struct packed {
		logic [31:0] key;
		logic [31:0] pending;
		logic        busy;
		logic [63:0] busy_occ;
		logic [63:0] last_occ;
	} slot_entry_t;

	typedef struct packed {
		logic        we;
		logic        set_used;
		slot_entry_t data;
	} slot_wr_t;

	typedef struct packed {
		logic        done;
		logic        hit;
		logic        free_found;
		slot_entry_t entry;
	} scan_stat_t;

endpackage

[rtl/todt_slot_table.sv]
// ----------------------------------------------------------------------------
// todt_slot_table
// Slot memory with used bits and a one-slot-per-cycle key search that also
// finds the lowest free slot.
// ----------------------------------------------------------------------------
module todt_slot_table import todt_pkg::*; #(
	parameter int SLOT_COUNT = DEF_SLOT_COUNT,
	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [31:0]      key,
	input  slot_wr_t         wr,
	input  logic [IDX_W-1:0] waddr,
	output scan_stat_t       stat,
	output logic [IDX_W-1:0] hit_idx,
	output logic [IDX_W-1:0] free_idx
);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

	slot_entry_t            slot_mem_q [SLOT_COUNT];
	slot_entry_t            rd_q;
	slot_entry_t            entry_q;
	logic [SLOT_COUNT-1:0]  used_q;
	logic                   scan_act_q;
	logic [IDX_W-1:0]       idx_q;
	logic                   cmp_vld_q;
	logic [IDX_W-1:0]       cmp_idx_q;
	logic                   hit_q;
	logic [IDX_W-1:0]       hit_idx_q;
	logic                   free_q;
	logic [IDX_W-1:0]       free_idx_q;
	logic                   done_q;
	logic                   key_eq;
	logic                   hit_now;
	logic                   free_now;

	// the one key comparator, reused for every slot
	assign key_eq   = (rd_q.key == key);
	assign hit_now  = cmp_vld_q && used_q[cmp_idx_q] && key_eq && !hit_q;
	assign free_now = cmp_vld_q && !used_q[cmp_idx_q] && !free_q;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			slot_mem_q[waddr] <= wr.data;
		end
		rd_q <= slot_mem_q[idx_q];
		if (hit_now) begin
			entry_q <= rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q     <= '0;
			scan_act_q <= 1'b0;
			idx_q      <= '0;
			cmp_vld_q  <= 1'b0;
			cmp_idx_q  <= '0;
			hit_q      <= 1'b0;
			hit_idx_q  <= '0;
			free_q     <= 1'b0;
			free_idx_q <= '0;
			done_q     <= 1'b0;
		end else begin
			if (wr.we && wr.set_used) begin
				used_q[waddr] <= 1'b1;
			end
			if (start) begin
				scan_act_q <= 1'b1;
				idx_q      <= '0;
				cmp_vld_q  <= 1'b0;
				hit_q      <= 1'b0;
				free_q     <= 1'b0;
				done_q     <= 1'b0;
			end else begin
				cmp_vld_q <= scan_act_q;
				cmp_idx_q <= idx_q;
				if (scan_act_q) begin
					if (idx_q == LAST_IDX) begin
						scan_act_q <= 1'b0;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				done_q <= cmp_vld_q && (cmp_idx_q == LAST_IDX);
				if (hit_now) begin
					hit_q     <= 1'b1;
					hit_idx_q <= cmp_idx_q;
				end
				if (free_now) begin
					free_q     <= 1'b1;
					free_idx_q <= cmp_idx_q;
				end
			end
		end
	end

	assign stat.done       = done_q;
	assign stat.hit        = hit_q;
	assign stat.free_found = free_q;
	assign stat.entry      = entry_q;
	assign hit_idx         = hit_idx_q;
	assign free_idx        = free_idx_q;

	a_hit_used: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && hit_q |-> used_q[hit_idx_q])
		else $error("matched slot is not in use");

	a_free_unused: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && free_q |-> !used_q[free_idx_q])
		else $error("free slot already in use");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !scan_act_q && !cmp_vld_q)
		else $error("search restarted while running");

	a_write_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		wr.we |-> !scan_act_q && !cmp_vld_q)
		else $error("slot write during search");

	a_done_end: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("search done held longer than one cycle");

endmodule

[rtl/timer_occurrence_dedup_tracker.sv]
// Tracks timer occurrences in a table of SLOT_COUNT slots, one per timer key
// (key zero counts as key one), and returns one result item per event item.
// The key search walks the slot memory one slot a cycle through a single
// comparator; a new event is accepted only in the idle state, after the last
// one has passed the search, update and finish states. A result waiting in
// the output register does not keep the next event from being accepted.
// ----------------------------------------------------------------------------
// timer_occurrence_dedup_tracker
// Event sequencer, running totals and stream ports of the tracker.
// ----------------------------------------------------------------------------
module timer_occurrence_dedup_tracker import todt_pkg::*; #(
	parameter int SLOT_COUNT = DEF_SLOT_COUNT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// timer_key[31:0], occurrence[95:32]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// mode[2:0]
	input  logic [IN_USER_W-1:0]  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// queued[0], table_full[1], timer_busy[2], timer_pending[34:3],
	// all_pending[66:35], deliveries[98:67], duplicates[130:99],
	// drops[162:131], peak_pending[194:163], verdict[196:195], zero[199:197]
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_we,
	input  logic [31:0]           cfg_wdata
);

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_UPDATE = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	state_t           state_q;
	logic [2:0]       mode_q;
	logic [31:0]      key_q;
	logic [63:0]      occ_q;
	logic [31:0]      limit_q;
	logic [31:0]      sum_q;
	logic [31:0]      deliv_q;
	logic [31:0]      dup_q;
	logic [31:0]      drop_q;
	logic [31:0]      peak_q;
	logic             res_queued_q;
	logic             res_full_q;
	logic             res_busy_q;
	logic [31:0]      res_pend_q;
	logic             m_tvalid_q;
	logic             out_queued_q;
	logic             out_full_q;
	logic             out_busy_q;
	logic [31:0]      out_pend_q;
	logic [31:0]      out_sum_q;
	logic [31:0]      out_deliv_q;
	logic [31:0]      out_dup_q;
	logic [31:0]      out_drop_q;
	logic [31:0]      out_peak_q;
	logic [1:0]       out_verdict_q;

	logic             accept;
	logic             start;
	scan_stat_t       stat;
	logic [IDX_W-1:0] hit_idx;
	logic [IDX_W-1:0] free_idx;
	slot_wr_t         wr;
	logic [IDX_W-1:0] waddr;

	logic             allocating;
	logic             slot_ok;
	slot_entry_t      base;
	slot_entry_t      nxt;
	logic             upd_queued;
	logic             upd_dup;
	logic             upd_drop;
	logic             upd_deliv;
	logic             upd_dec;
	logic             mode_known;
	logic             out_free;
	logic [1:0]       verdict;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign start    = accept;
	assign out_free = !m_tvalid_q || m_tready;

	todt_slot_table #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.key      (key_q),
		.wr       (wr),
		.waddr    (waddr),
		.stat     (stat),
		.hit_idx  (hit_idx),
		.free_idx (free_idx)
	);

	// event decode on the slot found by the search
	always_comb begin
		allocating = (mode_q == MODE_ARM) || (mode_q == MODE_TRY) ||
			(mode_q == MODE_BEGIN) || (mode_q == MODE_DROP);
		mode_known = allocating || (mode_q == MODE_DEQ) || (mode_q == MODE_END);
		slot_ok    = stat.hit || (allocating && stat.free_found);
		if (stat.hit) begin
			base = stat.entry;
		end else begin
			base     = '0;
			base.key = key_q;
		end
		nxt        = base;
		upd_queued = 1'b0;
		upd_dup    = 1'b0;
		upd_drop   = 1'b0;
		upd_deliv  = 1'b0;
		upd_dec    = 1'b0;
		unique case (mode_q)
			MODE_TRY: begin
				if (base.busy && (base.busy_occ == occ_q)) begin
					upd_dup = 1'b1;
				end else if ((base.pending != 32'd0) && (base.last_occ == occ_q)) begin
					upd_drop = 1'b1;
				end else begin
					nxt.pending = base.pending + 32'd1;
					nxt.last_occ = occ_q;
					upd_queued = 1'b1;
				end
			end
			MODE_DEQ: begin
				if (base.pending != 32'd0) begin
					nxt.pending = base.pending - 32'd1;
					upd_dec = 1'b1;
				end
			end
			MODE_BEGIN: begin
				if (base.busy) begin
					upd_dup = 1'b1;
				end else begin
					nxt.busy     = 1'b1;
					nxt.busy_occ = occ_q;
				end
			end
			MODE_END: begin
				nxt.busy     = 1'b0;
				nxt.busy_occ = '0;
				upd_deliv    = 1'b1;
			end
			MODE_DROP: begin
				upd_drop = 1'b1;
			end
			default: begin
			end
		endcase
		if (!slot_ok) begin
			upd_queued = 1'b0;
			upd_dup    = 1'b0;
			upd_drop   = 1'b0;
			upd_deliv  = 1'b0;
			upd_dec    = 1'b0;
		end
	end

	assign wr.we       = (state_q == ST_UPDATE) && slot_ok && mode_known;
	assign wr.set_used = !stat.hit;
	assign wr.data     = nxt;
	assign waddr       = stat.hit ? hit_idx : free_idx;

	always_comb begin
		if (dup_q != 32'd0) begin
			verdict = VERDICT_DUP;
		end else if (peak_q > limit_q) begin
			verdict = VERDICT_BACKLOG;
		end else begin
			verdict = VERDICT_VALID;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			limit_q    <= LIMIT_RESET;
			sum_q      <= '0;
			deliv_q    <= '0;
			dup_q      <= '0;
			drop_q     <= '0;
			peak_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if ((state_q == ST_FINISH) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (stat.done) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (upd_queued) begin
						sum_q <= sum_q + 32'd1;
						if (nxt.pending > peak_q) begin
							peak_q <= nxt.pending;
						end
					end
					if (upd_dec) begin
						sum_q <= sum_q - 32'd1;
					end
					if (upd_dup) begin
						dup_q <= dup_q + 32'd1;
					end
					if (upd_drop) begin
						drop_q <= drop_q + 32'd1;
					end
					if (upd_deliv) begin
						deliv_q <= deliv_q + 32'd1;
					end
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= s_tuser;
			key_q  <= (s_tdata[31:0] == 32'd0) ? 32'd1 : s_tdata[31:0];
			occ_q  <= s_tdata[95:32];
		end
		if (state_q == ST_UPDATE) begin
			res_queued_q <= upd_queued;
			res_full_q   <= allocating && !slot_ok;
			res_busy_q   <= slot_ok && nxt.busy;
			res_pend_q   <= slot_ok ? nxt.pending : 32'd0;
		end
		if ((state_q == ST_FINISH) && out_free) begin
			out_queued_q  <= res_queued_q;
			out_full_q    <= res_full_q;
			out_busy_q    <= res_busy_q;
			out_pend_q    <= res_pend_q;
			out_sum_q     <= sum_q;
			out_deliv_q   <= deliv_q;
			out_dup_q     <= dup_q;
			out_drop_q    <= drop_q;
			out_peak_q    <= peak_q;
			out_verdict_q <= verdict;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, out_verdict_q, out_peak_q, out_drop_q, out_dup_q,
		out_deliv_q, out_sum_q, out_pend_q, out_busy_q, out_full_q, out_queued_q};

	a_queued_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && out_queued_q |-> !out_full_q)
		else $error("item both queued and table full");

	a_sum_follows_queue: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE) && upd_queued |=> sum_q == $past(sum_q) + 32'd1)
		else $error("outstanding total missed a queued item");

	a_backlog_no_dup: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && (out_verdict_q == VERDICT_BACKLOG) |-> out_dup_q == 32'd0)
		else $error("backlog verdict with duplicates counted");

	a_peak_grows: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> peak_q >= $past(peak_q))
		else $error("peak outstanding went down");

endmodule

[tb/todt_tb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// todt_tb_pkg
// Result predictor and checker for the timer occurrence dedup tracker bench.
// Each accepted event item is run through a private copy of the slot table
// and the totals; each result item is compared field by field with the
// oldest prediction.
// ----------------------------------------------------------------------------
package todt_tb_pkg;
	import todt_pkg::*;

	localparam int TB_SLOTS = DEF_SLOT_COUNT;

	typedef struct packed {
		logic        queued;
		logic        table_full;
		logic        timer_busy;
		logic [31:0] timer_pending;
		logic [31:0] all_pending;
		logic [31:0] deliveries;
		logic [31:0] duplicates;
		logic [31:0] drops;
		logic [31:0] peak_pending;
		logic [1:0]  verdict;
	} tracker_result_t;

	class tracker_scoreboard;
		logic [31:0]     burst_limit;
		bit              slot_taken[TB_SLOTS];
		logic [31:0]     slot_timer[TB_SLOTS];
		logic [31:0]     slot_count[TB_SLOTS];
		bit              slot_inflight[TB_SLOTS];
		logic [63:0]     slot_inflight_occ[TB_SLOTS];
		logic [63:0]     slot_queued_occ[TB_SLOTS];
		logic [31:0]     delivered;
		logic [31:0]     duplicated;
		logic [31:0]     dropped;
		logic [31:0]     peak_outstanding;
		tracker_result_t expected_q[$];
		int              mismatches;

		function new();
			burst_limit = LIMIT_RESET;
			foreach (slot_taken[i]) begin
				slot_taken[i] = 1'b0;
				slot_timer[i] = '0;
				slot_count[i] = '0;
				slot_inflight[i] = 1'b0;
				slot_inflight_occ[i] = '0;
				slot_queued_occ[i] = '0;
			end
			delivered = '0;
			duplicated = '0;
			dropped = '0;
			peak_outstanding = '0;
			mismatches = 0;
		endfunction

		function int outstanding();
			return expected_q.size();
		endfunction

		function void note_item(logic [2:0] mode, logic [31:0] timer_key, logic [63:0] occ);
			logic [31:0]     k;
			bit              claims;
			int              s;
			tracker_result_t r;
			k = (timer_key == 32'd0) ? 32'd1 : timer_key;
			claims = (mode == MODE_ARM) || (mode == MODE_TRY) ||
				(mode == MODE_BEGIN) || (mode == MODE_DROP);
			s = -1;
			for (int i = 0; i < TB_SLOTS; i++)
				if (s < 0 && slot_taken[i] && slot_timer[i] == k)
					s = i;
			// allocating events take the lowest free slot, cleared
			if (s < 0 && claims) begin
				for (int i = 0; i < TB_SLOTS; i++)
					if (s < 0 && !slot_taken[i])
						s = i;
				if (s >= 0) begin
					slot_taken[s] = 1'b1;
					slot_timer[s] = k;
					slot_count[s] = '0;
					slot_inflight[s] = 1'b0;
					slot_inflight_occ[s] = '0;
					slot_queued_occ[s] = '0;
				end
			end
			r = '0;
			if (s < 0) begin
				r.table_full = claims;
			end else begin
				case (mode)
				MODE_TRY: begin
					if (slot_inflight[s] && slot_inflight_occ[s] == occ) begin
						duplicated++;
					end else if (slot_count[s] != 0 && slot_queued_occ[s] == occ) begin
						// repeat of the last queued occurrence is coalesced
						dropped++;
					end else begin
						slot_count[s]++;
						slot_queued_occ[s] = occ;
						if (slot_count[s] > peak_outstanding)
							peak_outstanding = slot_count[s];
						r.queued = 1'b1;
					end
				end
				MODE_DEQ: begin
					if (slot_count[s] != 0)
						slot_count[s]--;
				end
				MODE_BEGIN: begin
					if (slot_inflight[s]) begin
						duplicated++;
					end else begin
						slot_inflight[s] = 1'b1;
						slot_inflight_occ[s] = occ;
					end
				end
				MODE_END: begin
					slot_inflight[s] = 1'b0;
					slot_inflight_occ[s] = '0;
					delivered++;
				end
				MODE_DROP: begin
					dropped++;
				end
				default: begin
				end
				endcase
				r.timer_busy = slot_inflight[s];
				r.timer_pending = slot_count[s];
			end
			for (int i = 0; i < TB_SLOTS; i++)
				if (slot_taken[i])
					r.all_pending += slot_count[i];
			r.deliveries = delivered;
			r.duplicates = duplicated;
			r.drops = dropped;
			r.peak_pending = peak_outstanding;
			if (duplicated != 0)
				r.verdict = VERDICT_DUP;
			else if (peak_outstanding > burst_limit)
				r.verdict = VERDICT_BACKLOG;
			else
				r.verdict = VERDICT_VALID;
			expected_q.push_back(r);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch in %s: expected %0h, got %0h", name, want, got);
			end
		endfunction

		function void check_result(logic [OUT_DATA_W-1:0] data);
			tracker_result_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result item with no event waiting: %h", data);
				return;
			end
			want = expected_q.pop_front();
			compare_field("queued", 32'(want.queued), 32'(data[0]));
			compare_field("table_full", 32'(want.table_full), 32'(data[1]));
			compare_field("timer_busy", 32'(want.timer_busy), 32'(data[2]));
			compare_field("timer_pending", want.timer_pending, data[34:3]);
			compare_field("all_pending", want.all_pending, data[66:35]);
			compare_field("deliveries", want.deliveries, data[98:67]);
			compare_field("duplicates", want.duplicates, data[130:99]);
			compare_field("drops", want.drops, data[162:131]);
			compare_field("peak_pending", want.peak_pending, data[194:163]);
			compare_field("verdict", 32'(want.verdict), 32'(data[196:195]));
		endfunction
	endclass

endpackage

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level bench of the timer occurrence dedup tracker. A directed opening
// fills the slot table, reaches the backlog and duplicate verdicts and the
// table-full case, then random events over a small key set run under several
// backlog limits, with random gaps on the event side and random stalls on the
// result side.
// ----------------------------------------------------------------------------
module tb_top;
	import todt_pkg::*;
	import todt_tb_pkg::*;

	localparam int IDLE_LIMIT = 3000;
	localparam int CHUNK_ITEMS = 124;

	// event codes the block does not act on
	localparam logic [2:0] MODE_SPARE_A = 3'd6;
	localparam logic [2:0] MODE_SPARE_B = 3'd7;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [IN_USER_W-1:0]  s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_we = 1'b0;
	logic [31:0]           cfg_wdata = '0;

	tracker_scoreboard sb;
	int                idle_cycles = 0;
	int                tx_calm = 0;
	int                rx_hold = 0;
	int                rx_calm = 0;
	logic [63:0]       recent_occ = '0;

	timer_occurrence_dedup_tracker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// mostly keys that own a slot, now and then one that misses
	function automatic logic [31:0] pick_timer();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return $urandom;
		else if (r == 1)
			return 32'h0;
		else if (r == 2)
			return 32'hFFFF_FFFF;
		else if (r == 3)
			return 32'h8000_0000;
		else if (r < 7)
			return 32'h1;
		return $urandom_range(2, 6);
	endfunction

	// result side stalls
	always @(posedge clk) begin
		if (rx_hold > 0) begin
			rx_hold--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if (rx_calm > 0)
				rx_calm--;
			else if ($urandom_range(0, 99) < 3)
				rx_calm = $urandom_range(40, 200);
			else if ($urandom_range(0, 99) < 30)
				rx_hold = pick_gap();
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	task automatic send_item(input logic [2:0] mode, input logic [31:0] timer_key,
		input logic [63:0] occ);
		int gap;
		gap = 0;
		if (tx_calm > 0)
			tx_calm--;
		else if ($urandom_range(0, 99) < 2)
			tx_calm = $urandom_range(30, 120);
		else
			gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= {occ, timer_key};
		do @(posedge clk); while (!s_tready);
		sb.note_item(mode, timer_key, occ);
		recent_occ = occ;
	endtask

	task automatic send_random();
		logic [2:0]  mode;
		logic [63:0] occ;
		int          r;
		r = $urandom_range(0, 99);
		if (r < 8)
			mode = MODE_ARM;
		else if (r < 42)
			mode = MODE_TRY;
		else if (r < 60)
			mode = MODE_DEQ;
		else if (r < 73)
			mode = MODE_BEGIN;
		else if (r < 86)
			mode = MODE_END;
		else if (r < 95)
			mode = MODE_DROP;
		else
			mode = ($urandom_range(0, 1) != 0) ? MODE_SPARE_A : MODE_SPARE_B;
		// small occurrence values and repeats make drops and duplicates common
		r = $urandom_range(0, 99);
		if (r < 45)
			occ = 64'($urandom_range(0, 3));
		else if (r < 65)
			occ = recent_occ;
		else
			occ = {$urandom, $urandom};
		send_item(mode, pick_timer(), occ);
	endtask

	task automatic write_limit(input logic [31:0] value);
		s_tvalid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.burst_limit = value;
	endtask

	initial begin
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset limit, no duplicates yet
		send_item(MODE_ARM, 32'h0, 64'h0);
		send_item(MODE_DEQ, 32'h1, 64'h0);
		send_item(MODE_DEQ, 32'h55, 64'h0);
		send_item(MODE_TRY, 32'h1, 64'h0);
		send_item(MODE_TRY, 32'h1, 64'h0);
		send_item(MODE_TRY, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		for (int i = 1; i <= 4; i++)
			send_item(MODE_TRY, 32'h1, 64'(i));
		send_item(MODE_DEQ, 32'h0, 64'h0);
		send_item(MODE_BEGIN, 32'hFFFF_FFFF, 64'hAAAA_AAAA_5555_5555);
		send_item(MODE_END, 32'hFFFF_FFFF, 64'h0);
		send_item(MODE_END, 32'h77, 64'h0);
		send_item(MODE_DROP, 32'h8000_0000, 64'h0);
		send_item(MODE_SPARE_A, 32'h1, 64'h0);
		send_item(MODE_SPARE_B, 32'h1234, 64'h0);
		for (int k = 2; k <= 6; k++)
			send_item(MODE_ARM, 32'(k), 64'h0);
		// every slot taken now
		send_item(MODE_BEGIN, 32'h7, 64'h1);
		send_item(MODE_TRY, 32'h8, 64'h1);

		write_limit(32'hFFFF_FFFF);
		send_item(MODE_TRY, 32'h2, 64'h5555_5555_AAAA_AAAA);
		write_limit(32'h0);
		send_item(MODE_DEQ, 32'h2, 64'h0);
		send_item(MODE_BEGIN, 32'h3, 64'h0123_4567_89AB_CDEF);
		send_item(MODE_TRY, 32'h3, 64'h0123_4567_89AB_CDEF);
		send_item(MODE_BEGIN, 32'h3, 64'h0);

		for (int c = 0; c < 5; c++) begin
			write_limit((c == 4) ? 32'hFFFF_FFFF : 32'($urandom_range(0, 40)));
			repeat (CHUNK_ITEMS) send_random();
		end

		s_tvalid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (sb.mismatches == 0 && sb.outstanding() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
